@@ rtl/bfpa_pkg.sv @@
// Package for the bounded FIFO with pop averaging.
// Holds field widths, result tags, controller states and the control/status
// structs between controller and datapath. No dependencies.
package bfpa_pkg;

  // Fixed field widths
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned CAP_W  = 9;
  localparam int unsigned TAG_W  = 2;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned APB_W  = 32;

  // Configuration register file
  localparam logic [CAP_W-1:0] CAP_RESET   = 9'd256;
  localparam logic             REG_CAPACITY = 1'b0;

  // Input item kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result tags
  typedef enum logic [TAG_W-1:0] {
    TAG_AVG   = 2'd0,
    TAG_OVF   = 2'd1,
    TAG_EMPTY = 2'd2
  } tag_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OVF,
    ST_SUM,
    ST_DIV,
    ST_AVG,
    ST_EMPTY
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;      // input transaction taken this cycle
    logic walk;        // read and accumulate stored words
    logic div_start;   // launch the divider on the finished sum
    logic load_ovf;    // place an overflow notice in the output register
    logic load_avg;    // place the average in the output register
    logic load_empty;  // place an empty notice and clear the FIFO
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_pop;
    logic cnt_zero;
    logic occ_zero;
    logic ovf_notice;
    logic short_pop;
    logic walk_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/bfpa_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on bfpa_pkg for widths and the result tag type.
interface bfpa_in_if;
  import bfpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [VAL_W-1:0]  value;
  logic                     batch_start;
  logic        [CNT_W-1:0]  pop_count;

  modport source (output valid, kind, value, batch_start, pop_count, input ready);
  modport sink   (input valid, kind, value, batch_start, pop_count, output ready);
endinterface

interface bfpa_out_if;
  import bfpa_pkg::*;

  logic                    valid;
  logic                    ready;
  tag_e                    tag;
  logic signed [VAL_W-1:0] average;
  logic                    last;

  modport source (output valid, tag, average, last, input ready);
  modport sink   (input valid, tag, average, last, output ready);
endinterface

@@ rtl/bounded_fifo_pop_average.sv @@
// Bounded FIFO of signed words with averaging pops. A push that raises an
// overflow notice also loads it into the output register. A pop sums its n
// words in SUMW bits, where SUMW = min(DATA_WIDTH, 32) + 16 (48 by default):
// the stored words are read through the single memory read port one a cycle,
// then a radix-2 divider produces one quotient bit a cycle. A short pop adds
// a trailing empty notice. Results wait in an output register; the capacity
// register is written over the APB-style port.
// Depends on bfpa_pkg, bfpa_if, bfpa_ctrl and bfpa_dp.
module bounded_fifo_pop_average #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  bfpa_in_if.sink                              in_i,
  bfpa_out_if.source                           out_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bfpa_pkg::ADDR_W-1:0]          paddr,
  input  logic [bfpa_pkg::APB_W-1:0]           pwdata,
  output logic [bfpa_pkg::APB_W-1:0]           prdata,
  output logic                                 pready
);
  import bfpa_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             cap_sel;
  logic             cfg_wr;
  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic             in_ready;

  // Register access: index from the word address
  assign cap_sel = (paddr[2] == REG_CAPACITY);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = cap_sel ? APB_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr && cap_sel) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  bfpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bfpa_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cap_i            (cap_q),
    .in_kind_i        (in_i.kind),
    .in_value_i       (in_i.value),
    .in_batch_start_i (in_i.batch_start),
    .in_pop_count_i   (in_i.pop_count),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_tag_o        (out_o.tag),
    .out_average_o    (out_o.average),
    .out_last_o       (out_o.last)
  );

  assign in_i.ready = in_ready;

  // Results are only loaded into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_ovf || cmd.load_avg || cmd.load_empty) |-> status.out_free)
    else $error("result loaded over an untaken result");

  // At most one result source per cycle
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_ovf, cmd.load_avg, cmd.load_empty}))
    else $error("several result loads in one cycle");

  // The divider starts only on a complete sum
  a_div_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> (status.walk_done && status.div_done))
    else $error("divider started before the sum was complete");

  // An overflow notice appears at the output the cycle after it is loaded
  a_ovf_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_ovf |=> (out_o.valid && (out_o.tag == TAG_OVF) && out_o.last))
    else $error("overflow notice not presented");

endmodule

@@ rtl/bfpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bfpa_div.sv @@
// Radix-2 restoring divider: signed sum by unsigned word count, truncated
// toward zero. One quotient bit per cycle. Depends on bfpa_pkg.
module bfpa_div #(
  parameter int unsigned SUMW = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [SUMW-1:0]              dividend_i,
  input  logic        [bfpa_pkg::CNT_W-1:0]   divisor_i,
  output logic                                busy_o,
  output logic signed [bfpa_pkg::VAL_W-1:0]   quotient_o
);
  import bfpa_pkg::*;

  localparam int unsigned CW = $clog2(SUMW + 1);

  logic            busy_q, busy_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [SUMW-1:0] work_q, work_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] dvs_q, dvs_d;
  logic            neg_q, neg_d;
  logic [CNT_W:0]  trial;
  logic [CNT_W:0]  diff;
  logic [SUMW-1:0] mag;
  logic [VAL_W-1:0] q32;

  // Magnitude of the dividend
  assign mag = dividend_i[SUMW-1] ? (~dividend_i + SUMW'(1)) : dividend_i;

  // One restoring step
  assign trial = {rem_q, work_q[SUMW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(SUMW);
      work_d = mag;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[SUMW-1];
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = diff[CNT_W-1:0];
        work_d = {work_q[SUMW-2:0], 1'b1};
      end else begin
        rem_d  = trial[CNT_W-1:0];
        work_d = {work_q[SUMW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
  end

  // Apply the sign to the magnitude quotient
  assign q32        = VAL_W'(work_q);
  assign quotient_o = neg_q ? -q32 : q32;
  assign busy_o     = busy_q;

endmodule

@@ rtl/bfpa_dp.sv @@
// Datapath: FIFO pointers and occupancy, word store, sum accumulator,
// divider and output register. Depends on bfpa_pkg, bfpa_ram and bfpa_div.
module bfpa_dp #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [bfpa_pkg::CAP_W-1:0]           cap_i,
  input  logic                                 in_kind_i,
  input  logic signed [bfpa_pkg::VAL_W-1:0]    in_value_i,
  input  logic                                 in_batch_start_i,
  input  logic [bfpa_pkg::CNT_W-1:0]           in_pop_count_i,
  input  bfpa_pkg::ctrl_cmd_t                  cmd_i,
  output bfpa_pkg::dp_status_t                 status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output bfpa_pkg::tag_e                       out_tag_o,
  output logic signed [bfpa_pkg::VAL_W-1:0]    out_average_o,
  output logic                                 out_last_o
);
  import bfpa_pkg::*;

  localparam int unsigned SW   = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
  localparam int unsigned SUMW = SW + CNT_W;
  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned OCCW = $clog2(DEPTH + 1);
  localparam int unsigned CW   = (OCCW > CAP_W) ? OCCW : CAP_W;
  localparam int unsigned MW   = (OCCW > CNT_W) ? OCCW : CNT_W;

  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OCCW-1:0] occ_q, occ_d;
  logic            ovf_q, ovf_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic            short_q, short_d;
  logic            pend_q;
  logic [CNT_W-1:0] n_q;
  logic signed [SUMW-1:0] sum_q;
  logic            out_valid_q, out_valid_d;
  tag_e            out_tag_q;
  logic signed [VAL_W-1:0] out_avg_q;
  logic            out_last_q;

  logic [CW-1:0]   cap_ext, cap_eff, occ_c;
  logic            has_room, over, ovf_base;
  logic            is_pop, short_c, push_acc, pop_acc, store, issue, out_free;
  logic [CNT_W-1:0] take;
  logic [SW-1:0]   rdata;
  logic            div_busy;
  logic signed [VAL_W-1:0] quot;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    ptr_next = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Effective capacity saturates at the store depth
  assign cap_ext  = CW'(cap_i);
  assign cap_eff  = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
  assign occ_c    = CW'(occ_q);
  assign has_room = occ_c < cap_eff;
  assign over     = occ_c > cap_eff;
  assign ovf_base = in_batch_start_i ? over : ovf_q;

  // Pop request decode: a short pop takes every stored word
  assign is_pop  = (in_kind_i == KIND_POP);
  assign short_c = MW'(occ_q) < MW'(in_pop_count_i);
  assign take    = short_c ? CNT_W'(occ_q) : in_pop_count_i;

  assign push_acc = cmd_i.accept && !is_pop;
  assign pop_acc  = cmd_i.accept && is_pop && (in_pop_count_i != '0);
  assign store    = push_acc && has_room;
  assign issue    = cmd_i.walk && (rem_q != '0);
  assign out_free = !out_valid_q || out_ready_i;

  // Word store
  bfpa_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (wr_ptr_q),
    .wdata_i (in_value_i[SW-1:0]),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  // Average divider
  bfpa_div #(
    .SUMW (SUMW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (n_q),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  // FIFO bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    occ_d    = occ_q;
    ovf_d    = ovf_q;
    rem_d    = rem_q;
    short_d  = short_q;
    if (push_acc) begin
      ovf_d = has_room ? ovf_base : 1'b1;
    end
    if (store) begin
      wr_ptr_d = ptr_next(wr_ptr_q);
      occ_d    = occ_q + OCCW'(1);
    end
    if (pop_acc) begin
      occ_d   = OCCW'(MW'(occ_q) - MW'(take));
      rem_d   = take;
      short_d = short_c;
    end
    if (issue) begin
      rd_ptr_d = ptr_next(rd_ptr_q);
      rem_d    = rem_q - CNT_W'(1);
    end
    if (cmd_i.load_empty) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      occ_d    = '0;
    end
  end

  // Output register: load on command, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_ovf || cmd_i.load_avg || cmd_i.load_empty) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      occ_q       <= '0;
      ovf_q       <= 1'b0;
      rem_q       <= '0;
      short_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      occ_q       <= occ_d;
      ovf_q       <= ovf_d;
      rem_q       <= rem_d;
      short_q     <= short_d;
      pend_q      <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  // Accumulate read data in the cycle after its read is issued
  always_ff @(posedge clk_i) begin
    if (pop_acc) begin
      n_q   <= take;
      sum_q <= '0;
    end else if (pend_q) begin
      sum_q <= sum_q + {{CNT_W{rdata[SW-1]}}, rdata};
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ovf) begin
      out_tag_q  <= TAG_OVF;
      out_avg_q  <= '0;
      out_last_q <= 1'b1;
    end else if (cmd_i.load_avg) begin
      out_tag_q  <= TAG_AVG;
      out_avg_q  <= quot;
      out_last_q <= !short_q;
    end else if (cmd_i.load_empty) begin
      out_tag_q  <= TAG_EMPTY;
      out_avg_q  <= '0;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_tag_o     = out_tag_q;
  assign out_average_o = out_avg_q;
  assign out_last_o    = out_last_q;

  // Status towards the controller
  always_comb begin
    status_o.is_pop     = is_pop;
    status_o.cnt_zero   = (in_pop_count_i == '0);
    status_o.occ_zero   = (occ_q == '0);
    status_o.ovf_notice = !has_room && !ovf_base;
    status_o.short_pop  = short_q;
    status_o.walk_done  = (rem_q == '0) && !pend_q;
    status_o.div_done   = !div_busy;
    status_o.out_free   = out_free;
  end

endmodule

@@ rtl/bfpa_ctrl.sv @@
// Controller state machine: sequences push, walk, divide and result loads.
// Depends on bfpa_pkg.
module bfpa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bfpa_pkg::dp_status_t  status_i,
  output bfpa_pkg::ctrl_cmd_t   cmd_o
);
  import bfpa_pkg::*;

  ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!status_i.is_pop) begin
            if (status_i.ovf_notice) begin
              state_d = ST_OVF;
            end
          end else if (!status_i.cnt_zero) begin
            state_d = status_i.occ_zero ? ST_EMPTY : ST_SUM;
          end
        end
      end
      ST_OVF: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        if (status_i.walk_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_AVG;
        end
      end
      ST_AVG: begin
        if (status_i.out_free) begin
          state_d = status_i.short_pop ? ST_EMPTY : ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_OVF:   cmd_o.load_ovf = status_i.out_free;
      ST_SUM: begin
        cmd_o.walk      = 1'b1;
        cmd_o.div_start = status_i.walk_done;
      end
      ST_DIV:   cmd_o = '0;
      ST_AVG:   cmd_o.load_avg = status_i.out_free;
      ST_EMPTY: cmd_o.load_empty = status_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for bounded_fifo_pop_average: pushes, averaging pops and
// capacity changes over the APB-style port, checked against an internal predictor.
// Depends on bfpa_pkg, bfpa_if and the bounded_fifo_pop_average RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bfpa_pkg::*;

  localparam int unsigned FIFO_DEPTH        = 256;
  localparam int unsigned IDX_W             = $clog2(FIFO_DEPTH);
  localparam int unsigned SETTLE_CYCLES     = 320;
  localparam int unsigned RESULT_WAIT_LIMIT = 20000;
  localparam logic [ADDR_W-1:0] CAP_ADDR    = ADDR_W'(4 * REG_CAPACITY);

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] value;
    logic             batch_start;
    logic [CNT_W-1:0] pop_count;
  } fifo_item_t;

  typedef struct {
    tag_e             tag;
    logic [VAL_W-1:0] average;
    logic             last;
  } fifo_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  bfpa_in_if  in_if ();
  bfpa_out_if out_if ();

  bounded_fifo_pop_average dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state: a copy of the FIFO contents and the capacity register
  logic signed [VAL_W-1:0] held_words [FIFO_DEPTH];
  int unsigned             head_idx;
  int unsigned             tail_idx;
  int unsigned             held_count;
  logic                    notice_given;
  logic [CAP_W-1:0]        capacity_cfg;

  fifo_result_t expected_results [$];

  logic        sender_gaps;
  logic        receiver_stalls;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned cap_writes;
  int unsigned averages_seen;
  int unsigned overflows_seen;
  int unsigned empties_seen;

  function automatic void queue_result(input tag_e tag, input logic [VAL_W-1:0] average,
                                       input logic last);
    fifo_result_t r;
    r.tag     = tag;
    r.average = average;
    r.last    = last;
    expected_results.push_back(r);
  endfunction

  // Update the FIFO copy for one accepted transaction and queue what it yields
  function automatic void predict_item(input fifo_item_t item);
    int unsigned eff_cap;
    int unsigned idx;
    longint      sum;
    eff_cap = (capacity_cfg > FIFO_DEPTH) ? FIFO_DEPTH : capacity_cfg;
    sum     = 0;
    if (item.kind == KIND_PUSH) begin
      if (item.batch_start)
        notice_given = (held_count > eff_cap);
      if (held_count < eff_cap) begin
        held_words[IDX_W'(tail_idx)] = item.value;
        tail_idx   = (tail_idx + 1) % FIFO_DEPTH;
        held_count = held_count + 1;
      end else if (!notice_given) begin
        notice_given = 1'b1;
        queue_result(TAG_OVF, '0, 1'b1);
      end
    end else if (item.pop_count != 0) begin
      if (held_count < item.pop_count) begin
        // Short pop: average whatever is held, then clear and flag empty
        if (held_count != 0) begin
          idx = head_idx;
          for (int unsigned i = 0; i < held_count; i++) begin
            sum += held_words[IDX_W'(idx)];
            idx = (idx + 1) % FIFO_DEPTH;
          end
          queue_result(TAG_AVG, VAL_W'(sum / longint'(held_count)), 1'b0);
        end
        head_idx   = 0;
        tail_idx   = 0;
        held_count = 0;
        queue_result(TAG_EMPTY, '0, 1'b1);
      end else begin
        for (int unsigned i = 0; i < item.pop_count; i++) begin
          sum += held_words[IDX_W'(head_idx)];
          head_idx = (head_idx + 1) % FIFO_DEPTH;
        end
        held_count = held_count - item.pop_count;
        queue_result(TAG_AVG, VAL_W'(sum / longint'(item.pop_count)), 1'b1);
      end
    end
  endfunction

  // Drive one transaction, with an occasional gap beforehand, and predict on acceptance
  task automatic send_item(input fifo_item_t item);
    @(negedge clk_i);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= item.kind;
    in_if.value       <= item.value;
    in_if.batch_start <= item.batch_start;
    in_if.pop_count   <= item.pop_count;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_item(item);
    items_sent++;
  endtask

  task automatic push_word(input logic [VAL_W-1:0] value, input logic batch_start);
    fifo_item_t item;
    item.kind        = KIND_PUSH;
    item.value       = value;
    item.batch_start = batch_start;
    item.pop_count   = CNT_W'($urandom_range(0, 65535));
    send_item(item);
  endtask

  task automatic request_pop(input logic [CNT_W-1:0] count);
    fifo_item_t item;
    item.kind        = KIND_POP;
    item.value       = $urandom;
    item.batch_start = 1'($urandom_range(0, 1));
    item.pop_count   = count;
    send_item(item);
  endtask

  function automatic logic [VAL_W-1:0] random_word();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Hold the sender until every expected result is in, then let the block settle
  task automatic wait_for_results();
    int unsigned waited;
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < RESULT_WAIT_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count += expected_results.size();
      expected_results.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the capacity register while idle, then read it back
  task automatic program_capacity(input logic [CAP_W-1:0] cap);
    wait_for_results();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= APB_W'(cap);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    capacity_cfg = cap;
    cap_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== APB_W'(capacity_cfg)) begin
      $error("capacity readback: expected %0d, actual %0d", capacity_cfg, prdata);
      error_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Field extremes, rounding toward zero, ignored and short pops
  task automatic test_directed();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    request_pop(16'd1);
    push_word(32'h7FFF_FFFF, 1'b1);
    push_word(32'h8000_0000, 1'b0);
    request_pop(16'd2);
    push_word(-32'sd7, 1'b1);
    push_word(32'sd2, 1'b0);
    request_pop(16'd2);
    push_word(32'sd5, 1'b1);
    request_pop(16'd0);
    request_pop(16'd1);
    push_word(32'h8000_0000, 1'b1);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h8000_0000, 1'b0);
    request_pop(16'hFFFF);
    push_word(32'h7FFF_FFFF, 1'b1);
    push_word(32'h7FFF_FFFF, 1'b0);
    request_pop(16'd2);
    push_word(32'hA5A5_A5A5, 1'b1);
    push_word(32'h5A5A_5A5A, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    request_pop(16'd4);
  endtask

  // Zero and saturated capacity, and a capacity lowered under the fill level
  task automatic test_capacity_limits();
    program_capacity(9'd0);
    push_word(random_word(), 1'b1);
    push_word(random_word(), 1'b0);
    push_word(random_word(), 1'b1);
    request_pop(16'd1);

    program_capacity(9'd511);
    for (int i = 0; i < FIFO_DEPTH + 2; i++)
      push_word(random_word(), i == 0);
    request_pop(16'(FIFO_DEPTH));

    program_capacity(9'd256);
    for (int i = 0; i < 10; i++)
      push_word(random_word(), i == 0);
    program_capacity(9'd4);
    push_word(random_word(), 1'b1);
    push_word(random_word(), 1'b0);
    request_pop(16'd7);
    push_word(random_word(), 1'b1);
    push_word(random_word(), 1'b0);
    push_word(random_word(), 1'b0);
    request_pop(16'hFFFF);
  endtask

  // Mostly push batches followed by a pop, with stray pushes and pops mixed in
  task automatic run_traffic(input int unsigned n_items);
    int unsigned done_items;
    int unsigned eff_cap;
    int unsigned batch_len;
    int unsigned roll;
    logic [CNT_W-1:0] count;
    done_items = 0;
    while (done_items < n_items) begin
      eff_cap = (capacity_cfg > FIFO_DEPTH) ? FIFO_DEPTH : capacity_cfg;
      roll    = $urandom_range(0, 99);
      if (roll < 75) begin
        batch_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff_cap + 3)
                                                : $urandom_range(1, 8);
        for (int unsigned i = 0; i < batch_len; i++)
          push_word(random_word(), (i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0);
        done_items += batch_len;
        roll = $urandom_range(0, 99);
        if (roll < 70)
          count = CNT_W'($urandom_range(1, (held_count == 0) ? 1 : held_count));
        else if (roll < 85)
          count = CNT_W'(held_count + $urandom_range(1, 3));
        else if (roll < 95)
          count = CNT_W'($urandom_range(0, 65535));
        else
          count = '0;
      end else if (roll < 90) begin
        push_word(random_word(), 1'($urandom_range(0, 1)));
        done_items++;
        count = '0;
        continue;
      end else begin
        count = CNT_W'($urandom_range(0, 65535));
      end
      request_pop(count);
      if (count != 0)
        done_items++;
    end
  endtask

  task automatic test_random_traffic();
    program_capacity(9'd4);
    run_traffic(120);
    sender_gaps = 1'b0;
    program_capacity(9'd1);
    run_traffic(80);
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b0;
    program_capacity(9'd300);
    run_traffic(120);
    receiver_stalls = 1'b1;
    program_capacity(9'd0);
    run_traffic(30);
    program_capacity(CAP_W'($urandom_range(2, 40)));
    run_traffic(160);
    // closing stretch at full rate on both sides
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    program_capacity(9'd511);
    run_traffic(200);
  endtask

  // Result receiver: ready with random stall bursts
  initial begin : result_sink
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    fifo_result_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      case (out_if.tag)
        TAG_AVG:   averages_seen++;
        TAG_OVF:   overflows_seen++;
        TAG_EMPTY: empties_seen++;
        default:   ;
      endcase
      if (expected_results.size() == 0) begin
        $error("unexpected result: tag %0d, average %0d", out_if.tag, out_if.average);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.tag !== want.tag) begin
          $error("tag: expected %0d, actual %0d", want.tag, out_if.tag);
          error_count++;
        end
        if (out_if.average !== want.average) begin
          $error("average: expected %0d, actual %0d", $signed(want.average), out_if.average);
          error_count++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_if.last);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : test_sequence
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_PUSH;
    in_if.value       = '0;
    in_if.batch_start = 1'b0;
    in_if.pop_count   = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    head_idx          = 0;
    tail_idx          = 0;
    held_count        = 0;
    notice_given      = 1'b0;
    capacity_cfg      = CAP_RESET;
    sender_gaps       = 1'b0;
    receiver_stalls   = 1'b0;
    error_count       = 0;
    items_sent        = 0;
    cap_writes        = 0;
    averages_seen     = 0;
    overflows_seen    = 0;
    empties_seen      = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_capacity_limits();
    test_random_traffic();
    wait_for_results();

    $display("Covered %0d input transactions over %0d capacity writes (0, 1, 256, 511 included)",
             items_sent, cap_writes);
    $display("Checked %0d averages, %0d overflow notices and %0d empty notices",
             averages_seen, overflows_seen, empties_seen);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
